### rtl/core/twcs_pkg.sv
// Shared types, constants and helpers for the textured wall column stepper.
// No dependencies; every other file in rtl/core imports this package.
package twcs_pkg;

  localparam int MAX_ROWS         = 2048;
  localparam int MAX_TEXTURE_SIDE = 256;

  localparam int DIV_NUM_W = 28;  // screen_height << 16 at most
  localparam int DIV_DEN_W = 24;  // perp_distance width

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [1:0] CFG_SCREEN_HEIGHT  = 2'd0;
  localparam logic [1:0] CFG_VIEW_OFFSET    = 2'd1;
  localparam logic [1:0] CFG_TEXTURE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_TEXTURE_HEIGHT = 2'd3;

  localparam logic [1:0] TEX_SOUTH = 2'd0;
  localparam logic [1:0] TEX_NORTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [11:0] column;
    logic [23:0] perp;
    logic        side;
    logic        dx_neg;
    logic        dx_pos;
    logic        dy_pos;
    logic [15:0] frac;
  } in_item_t;

  typedef struct packed {
    logic [11:0] column;
    logic [10:0] row;
    logic [1:0]  tex;
    logic [7:0]  tx;
    logic [7:0]  ty;
    logic        last;
    logic        none;
  } out_item_t;

  typedef struct packed {
    logic        active;
    logic [10:0] cur_row;
    logic [10:0] end_row;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_ROWS,
    ST_DIV2,
    ST_MUL,
    ST_EMIT
  } back_state_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_ITEM_W = $bits(out_item_t);

  function automatic logic [11:0] clamp_rows(input logic [11:0] v);
    logic [11:0] r;
    r = v;
    if (v == 12'd0) r = 12'd1;
    else if (v > 12'(MAX_ROWS)) r = 12'(MAX_ROWS);
    return r;
  endfunction

  function automatic logic [8:0] clamp_side(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'(MAX_TEXTURE_SIDE)) r = 9'(MAX_TEXTURE_SIDE);
    return r;
  endfunction

endpackage

### rtl/core/twcs_fifo.sv
// Two-entry item queue with full/empty flags.
// Depends on twcs_pkg for the default item width.
module twcs_fifo #(
  parameter int WIDTH = twcs_pkg::IN_ITEM_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import twcs_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

endmodule

### rtl/core/twcs_div.sv
// Restoring divider, one quotient bit per cycle, shared by both column divisions.
// Depends on twcs_pkg for operand widths.
module twcs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [twcs_pkg::DIV_NUM_W-1:0] num,
  input  logic [twcs_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [twcs_pkg::DIV_NUM_W-1:0] quot
);
  import twcs_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r, done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W:0]   shifted, trial;
  logic                 ge;

  assign shifted = {rem_r, q_r[DIV_NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_r});
  assign trial   = ge ? (shifted - {1'b0, den_r}) : shifted;
  assign done    = done_r;
  assign quot    = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_NUM_W-2:0], ge};
      rem_r <= trial[DIV_DEN_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/twcs_back.sv
// Back end: runs start items through the column setup, steps on advance items and emits pixel items.
// Depends on twcs_pkg and twcs_div.
module twcs_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  twcs_pkg::in_item_t      in_item,
  input  logic                    in_empty,
  output logic                    in_pop,
  input  logic                    out_full,
  output logic                    out_push,
  output twcs_pkg::out_item_t     out_item,
  input  logic [11:0]             screen_height,
  input  logic signed [11:0]      view_offset,
  input  logic [8:0]              texture_width,
  input  logic [8:0]              texture_height,
  output twcs_pkg::back_status_t  status
);
  import twcs_pkg::*;

  back_state_t state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  logic [11:0] h_r, h_nxt;
  logic [8:0]  tw_r, tw_nxt, th_r, th_nxt;
  logic [15:0] lh_r, lh_nxt, offs_r, offs_nxt;
  logic [24:0] step_r, step_nxt;
  logic [47:0] pos_r, pos_nxt;
  logic [10:0] cur_r, cur_nxt, end_r, end_nxt;
  logic        active_r, active_nxt;
  logic [11:0] held_col_r, held_col_nxt;
  logic [1:0]  held_tex_r, held_tex_nxt;
  logic [7:0]  held_tx_r, held_tx_nxt;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  logic [11:0] h_cl;
  logic [8:0]  tw_cl, th_cl, th_m1;
  logic [7:0]  ty;
  logic        last;
  out_item_t   pix_item;

  logic signed [17:0] centre, half, first_raw, first_s, last_raw, last_s, h_s, offs_s;
  logic               empty_col;
  logic [24:0]        fx_prod;
  logic [7:0]         tx_raw, tx;
  logic               mirror;
  logic [1:0]         tex;

  twcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign h_cl  = clamp_rows(screen_height);
  assign tw_cl = clamp_side(texture_width);
  assign th_cl = clamp_side(texture_height);
  assign th_m1 = th_cl - 9'd1;

  // current pixel from held column state
  assign ty   = (pos_r[47:16] > {24'd0, th_m1[7:0]}) ? th_m1[7:0] : pos_r[23:16];
  assign last = ({1'b0, cur_r} + 12'd1) >= {1'b0, end_r};
  always_comb begin
    pix_item.column = held_col_r;
    pix_item.row    = cur_r;
    pix_item.tex    = held_tex_r;
    pix_item.tx     = held_tx_r;
    pix_item.ty     = ty;
    pix_item.last   = last;
    pix_item.none   = 1'b0;
  end

  // row span of a new column
  assign centre    = $signed({7'd0, h_r[11:1]}) + $signed({{6{view_offset[11]}}, view_offset});
  assign half      = $signed({3'd0, lh_r[15:1]});
  assign h_s       = $signed({6'd0, h_r});
  assign first_raw = centre - half;
  assign first_s   = first_raw[17] ? 18'sd0 : first_raw;
  assign last_raw  = centre + half;
  assign last_s    = (last_raw >= h_s) ? (h_s - 18'sd1) : last_raw;
  assign empty_col = (first_s >= last_s);
  assign offs_s    = first_s - centre + half;

  // texture column and face
  assign fx_prod = {9'd0, item_r.frac} * {16'd0, tw_r};
  assign tx_raw  = fx_prod[23:16];
  assign mirror  = (!item_r.side && item_r.dx_neg) || (item_r.side && item_r.dy_pos);
  assign tx      = mirror ? 8'(tw_r - {1'b0, tx_raw} - 9'd1) : tx_raw;
  assign tex     = item_r.side ? (item_r.dy_pos ? TEX_SOUTH : TEX_NORTH)
                               : (item_r.dx_pos ? TEX_EAST : TEX_WEST);

  assign status.active  = active_r;
  assign status.cur_row = cur_r;
  assign status.end_row = end_r;

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    h_nxt        = h_r;
    tw_nxt       = tw_r;
    th_nxt       = th_r;
    lh_nxt       = lh_r;
    offs_nxt     = offs_r;
    step_nxt     = step_r;
    pos_nxt      = pos_r;
    cur_nxt      = cur_r;
    end_nxt      = end_r;
    active_nxt   = active_r;
    held_col_nxt = held_col_r;
    held_tex_nxt = held_tex_r;
    held_tx_nxt  = held_tx_r;
    in_pop       = 1'b0;
    out_push     = 1'b0;
    out_item     = pix_item;
    div_start    = 1'b0;
    div_num      = {h_cl, 16'd0};
    div_den      = in_item.perp;

    unique case (state_r)
      ST_IDLE: begin
        if (!in_empty && !out_full) begin
          in_pop = 1'b1;
          if (in_item.opcode == OP_ADVANCE) begin
            out_push = 1'b1;
            if (active_r) begin
              cur_nxt = cur_r + 11'd1;
              pos_nxt = pos_r + {23'd0, step_r};
              if (last) active_nxt = 1'b0;
            end else begin
              out_item        = '0;
              out_item.column = held_col_r;
              out_item.none   = 1'b1;
            end
          end else begin
            item_nxt     = in_item;
            held_col_nxt = in_item.column;
            active_nxt   = 1'b0;
            h_nxt        = h_cl;
            tw_nxt       = tw_cl;
            th_nxt       = th_cl;
            div_start    = 1'b1;
            state_nxt    = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          // zero distance or quotient over 16 bits saturates
          lh_nxt = (item_r.perp == 24'd0 || div_quot[27:16] != 12'd0) ? 16'hFFFF
                                                                        : div_quot[15:0];
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (empty_col) begin
          if (!out_full) begin
            out_push        = 1'b1;
            out_item        = '0;
            out_item.column = item_r.column;
            out_item.none   = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cur_nxt      = first_s[10:0];
          end_nxt      = last_s[10:0];
          offs_nxt     = offs_s[15:0];
          held_tex_nxt = tex;
          held_tx_nxt  = tx;
          div_start    = 1'b1;
          div_num      = {3'd0, th_r, 16'd0};
          div_den      = {8'd0, lh_r};
          state_nxt    = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          step_nxt  = div_quot[24:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        pos_nxt    = {32'd0, offs_r} * {23'd0, step_r};
        active_nxt = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_full) begin
          out_push  = 1'b1;
          cur_nxt   = cur_r + 11'd1;
          pos_nxt   = pos_r + {23'd0, step_r};
          if (last) active_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= 1'b0;
      held_col_r <= 12'd0;
      cur_r      <= 11'd0;
      end_r      <= 11'd0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      held_col_r <= held_col_nxt;
      cur_r      <= cur_nxt;
      end_r      <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    h_r        <= h_nxt;
    tw_r       <= tw_nxt;
    th_r       <= th_nxt;
    lh_r       <= lh_nxt;
    offs_r     <= offs_nxt;
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    held_tex_r <= held_tex_nxt;
    held_tx_r  <= held_tx_nxt;
  end

endmodule

### rtl/core/textured_wall_column_stepper.sv
// Textured wall column stepper: the back end steps an active column on each advance
// item; a start item runs two passes of the shared serial divider (one pass when the
// column turns out empty).
// Input and result queues are two items deep, so input is taken while results wait.
// Reset (rst_n low, synchronous) empties both queues, drops any active column and
// restores screen_height 480, view_offset 0, texture size 64 x 64.
module textured_wall_column_stepper (
  input  logic               clk,
  input  logic               rst_n,
  // input queue side
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_opcode,
  input  logic [11:0]        in_screen_column,
  input  logic [23:0]        in_perp_distance,
  input  logic               in_hit_side,
  input  logic signed [15:0] in_ray_dir_x,
  input  logic signed [15:0] in_ray_dir_y,
  input  logic [15:0]        in_wall_fraction,
  // result queue side
  output logic               out_empty,
  input  logic               out_pop,
  output logic [11:0]        out_column,
  output logic [10:0]        out_row,
  output logic [1:0]         out_texture_select,
  output logic [7:0]         out_texel_x,
  output logic [7:0]         out_texel_y,
  output logic               out_last_row,
  output logic               out_no_pixel,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import twcs_pkg::*;

  logic [11:0]        screen_height_r;
  logic signed [11:0] view_offset_r;
  logic [8:0]         texture_width_r, texture_height_r;

  in_item_t     in_wr, in_rd;
  logic         in_empty, in_pop;
  out_item_t    res_wr, res_rd;
  logic         res_full, res_push;
  back_status_t bk_status;

  // config regs are always writable; the host must write them only with no item in flight; the block never checks
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r  <= 12'd480;
      view_offset_r    <= 12'sd0;
      texture_width_r  <= 9'd64;
      texture_height_r <= 9'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT:  screen_height_r  <= cfg_data;
        CFG_VIEW_OFFSET:    view_offset_r    <= $signed(cfg_data);
        CFG_TEXTURE_WIDTH:  texture_width_r  <= cfg_data[8:0];
        CFG_TEXTURE_HEIGHT: texture_height_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // front: only the direction signs travel on
  always_comb begin
    in_wr.opcode = in_opcode;
    in_wr.column = in_screen_column;
    in_wr.perp   = in_perp_distance;
    in_wr.side   = in_hit_side;
    in_wr.dx_neg = in_ray_dir_x[15];
    in_wr.dx_pos = !in_ray_dir_x[15] && (in_ray_dir_x != 16'sd0);
    in_wr.dy_pos = !in_ray_dir_y[15] && (in_ray_dir_y != 16'sd0);
    in_wr.frac   = in_wall_fraction;
  end

  twcs_fifo #(.WIDTH(IN_ITEM_W)) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_wr),
    .full  (in_full),
    .pop   (in_pop),
    .rdata (in_rd),
    .empty (in_empty)
  );

  twcs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_rd),
    .in_empty       (in_empty),
    .in_pop         (in_pop),
    .out_full       (res_full),
    .out_push       (res_push),
    .out_item       (res_wr),
    .screen_height  (screen_height_r),
    .view_offset    (view_offset_r),
    .texture_width  (texture_width_r),
    .texture_height (texture_height_r),
    .status         (bk_status)
  );

  twcs_fifo #(.WIDTH(OUT_ITEM_W)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rd),
    .empty (out_empty)
  );

  assign out_column         = res_rd.column;
  assign out_row            = res_rd.row;
  assign out_texture_select = res_rd.tex;
  assign out_texel_x        = res_rd.tx;
  assign out_texel_y        = res_rd.ty;
  assign out_last_row       = res_rd.last;
  assign out_no_pixel       = res_rd.none;

  // back end never drops a result into a full queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // back end never takes from an empty input queue
  a_no_in_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_pop |-> !in_empty) else $error("input popped from empty queue");

  // an active column always has a row left to draw
  a_active_rows: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.active |-> (bk_status.cur_row < bk_status.end_row))
    else $error("active column with no rows left");

endmodule

### bench/textured_wall_column_stepper_tb.sv
// Testbench for textured_wall_column_stepper: directed and random column items.
// A built-in predictor checks every pixel item; depends on twcs_pkg and the RTL.
`timescale 1ns / 1ps
module textured_wall_column_stepper_tb;
  import twcs_pkg::*;

  typedef struct {
    logic               opcode;
    logic [11:0]        column;
    logic [23:0]        perp;
    logic               side;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        frac;
  } ray_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_opcode = OP_START;
  logic [11:0] in_screen_column = '0;
  logic [23:0] in_perp_distance = '0;
  logic in_hit_side = 1'b0;
  logic signed [15:0] in_ray_dir_x = '0;
  logic signed [15:0] in_ray_dir_y = '0;
  logic [15:0] in_wall_fraction = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [11:0] out_column;
  logic [10:0] out_row;
  logic [1:0] out_texture_select;
  logic [7:0] out_texel_x, out_texel_y;
  logic out_last_row, out_no_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_SCREEN_HEIGHT;
  logic [11:0] cfg_data = '0;

  always #1 clk = ~clk;

  textured_wall_column_stepper uut (.*);

  // Register shadows, raw as written; clamping happens in the predictor.
  logic [11:0] sh_rows = 12'd480;
  logic signed [11:0] sh_offset = '0;
  logic [8:0] sh_tex_w = 9'd64, sh_tex_h = 9'd64;

  // Column state of the predictor.
  bit active;
  longint unsigned cur_row, stop_row, hold_col, hold_tex, hold_tx;
  longint unsigned tex_pos, tex_step;

  ray_item_t pending_rays[$];
  out_item_t pixel_q[$];
  ray_item_t drv_item;
  int errors = 0;
  int in_gap = 0, out_gap = 0;
  bit no_idle = 0;
  int quiet_cycles = 0;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_item_t blank_pixel(logic [11:0] col);
    out_item_t o;
    o = '0;
    o.column = col;
    o.none = 1'b1;
    return o;
  endfunction

  function out_item_t next_pixel();
    out_item_t o;
    longint unsigned ty, th;
    th = clampv(sh_tex_h, 1, MAX_TEXTURE_SIDE);
    ty = tex_pos >> 16;
    if (ty > th - 1) ty = th - 1;
    o.column = hold_col[11:0];
    o.row = cur_row[10:0];
    o.tex = hold_tex[1:0];
    o.tx = hold_tx[7:0];
    o.ty = ty[7:0];
    o.last = (cur_row + 1 >= stop_row);
    o.none = 1'b0;
    cur_row++;
    tex_pos = (tex_pos + tex_step) & 48'hFFFF_FFFF_FFFF;
    if (o.last) active = 0;
    return o;
  endfunction

  function out_item_t step_column(ray_item_t r);
    longint h, tw, th, lh, half, centre, first, lend, x;
    if (r.opcode == OP_ADVANCE) begin
      if (!active) return blank_pixel(hold_col[11:0]);
      return next_pixel();
    end
    h = clampv(sh_rows, 1, MAX_ROWS);
    tw = clampv(sh_tex_w, 1, MAX_TEXTURE_SIDE);
    th = clampv(sh_tex_h, 1, MAX_TEXTURE_SIDE);
    if (r.perp == 0) lh = 65535;
    else lh = clampv((h << 16) / longint'(r.perp), 0, 65535);
    half = lh / 2;
    centre = h / 2 + longint'(sh_offset);
    first = clampv(centre - half, 0, centre - half);
    lend = centre + half;
    if (lend >= h) lend = h - 1;
    hold_col = r.column;
    active = 0;
    if (first >= lend) return blank_pixel(r.column);
    if (r.side) hold_tex = (r.dy > 0) ? TEX_SOUTH : TEX_NORTH;
    else hold_tex = (r.dx > 0) ? TEX_EAST : TEX_WEST;
    x = (longint'(r.frac) * tw) >> 16;
    // mirror so the texture reads the same way from both faces
    if ((!r.side && r.dx < 0) || (r.side && r.dy > 0)) x = tw - x - 1;
    hold_tx = x;
    tex_step = (th << 16) / lh;
    tex_pos = (longint'(first - centre + half) * tex_step) & 48'hFFFF_FFFF_FFFF;
    cur_row = first;
    stop_row = lend;
    active = 1;
    return next_pixel();
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Input driver: one item per push, random bursts of holdoff.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        pixel_q.push_back(step_column(drv_item));
      end
      if (!in_push || !in_full) begin
        if (in_gap > 0) begin
          in_gap--;
          in_push <= 1'b0;
        end else if (pending_rays.size() > 0) begin
          drv_item = pending_rays.pop_front();
          in_opcode <= drv_item.opcode;
          in_screen_column <= drv_item.column;
          in_perp_distance <= drv_item.perp;
          in_hit_side <= drv_item.side;
          in_ray_dir_x <= drv_item.dx;
          in_ray_dir_y <= drv_item.dy;
          in_wall_fraction <= drv_item.frac;
          in_push <= 1'b1;
          if (!no_idle && $urandom_range(0, 19) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each popped item with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        quiet_cycles <= 0;
        if (pixel_q.size() == 0) begin
          $display("unexpected item col %0d row %0d", out_column, out_row);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (out_column !== want.column) report("column", out_column, want.column);
          if (out_row !== want.row) report("row", out_row, want.row);
          if (out_texture_select !== want.tex)
            report("texture_select", out_texture_select, want.tex);
          if (out_texel_x !== want.tx) report("texel_x", out_texel_x, want.tx);
          if (out_texel_y !== want.ty) report("texel_y", out_texel_y, want.ty);
          if (out_last_row !== want.last) report("last_row", out_last_row, want.last);
          if (out_no_pixel !== want.none) report("no_pixel", out_no_pixel, want.none);
        end
      end else if ((in_push && !in_full) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!no_idle && $urandom_range(0, 14) == 0) out_gap = $urandom_range(1, 16);
      end
    end
  end

  // Watchdog: ends the run and reports errors once the quiet counter reaches its limit.
  always @(posedge clk) begin
    if (quiet_cycles >= 3000) begin
      $display("watchdog expired at %0t", $realtime);
      $display("textured_wall_column_stepper_tb: done, errors");
      $finish;
    end
  end

  task automatic add_ray(logic op, logic [11:0] col, logic [23:0] perp, logic side,
                         logic [15:0] dx, logic [15:0] dy, logic [15:0] frac);
    ray_item_t r;
    r.opcode = op; r.column = col; r.perp = perp; r.side = side;
    r.dx = dx; r.dy = dy; r.frac = frac;
    pending_rays.push_back(r);
  endtask

  task automatic add_advances(int n);
    repeat (n) add_ray(OP_ADVANCE, 12'($urandom), 24'($urandom), 1'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly a start followed by a run of advances; some noise and cut-off columns.
  task automatic add_random(int n);
    int k;
    logic [23:0] perp;
    while (n > 0) begin
      case ($urandom_range(0, 9))
        0: perp = 24'($urandom);
        1: perp = 24'($urandom_range(0, 4));
        2: perp = 24'($urandom_range(24'h10000, 24'h800000));
        default: perp = 24'($urandom_range(24'h4000, 24'h60000));
      endcase
      add_ray(OP_START, 12'($urandom), perp, 1'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 40);
      if ($urandom_range(0, 24) == 0) k = 260;
      add_advances(k);
      n -= k + 1;
    end
  endtask

  // Wait until every prediction has been popped, then let the block settle.
  task automatic drain();
    do @(posedge clk); while (pending_rays.size() != 0 || in_push || in_gap != 0 ||
                              pixel_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SCREEN_HEIGHT:  sh_rows = val;
      CFG_VIEW_OFFSET:    sh_offset = val;
      CFG_TEXTURE_WIDTH:  sh_tex_w = val[8:0];
      CFG_TEXTURE_HEIGHT: sh_tex_h = val[8:0];
    endcase
  endtask

  task automatic set_regs(logic [11:0] rows, logic [11:0] offs, logic [11:0] tw,
                          logic [11:0] th);
    write_reg(CFG_SCREEN_HEIGHT, rows);
    write_reg(CFG_VIEW_OFFSET, offs);
    write_reg(CFG_TEXTURE_WIDTH, tw);
    write_reg(CFG_TEXTURE_HEIGHT, th);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed, reset settings: 480 rows, 64x64 textures
    add_ray(OP_ADVANCE, 12'hFFF, '0, 0, '0, '0, '0);              // advance while idle
    add_ray(OP_START, 12'hFFF, 24'h0, 0, 16'h8000, 16'h0, 16'hFFFF); // zero distance
    add_advances(2);
    add_ray(OP_START, 12'h000, 24'hFFFFFF, 1, 16'h0, 16'h7FFF, 16'h0); // empty column
    add_ray(OP_ADVANCE, 12'h123, '0, 0, '0, '0, '0);
    add_ray(OP_START, 12'h0A5, 24'h300000, 1, 16'h7FFF, 16'h7FFF, 16'h8000);
    add_advances(11);                        // runs through the last row, then idle
    add_ray(OP_START, 12'h5A0, 24'h10000, 1, 16'h0, 16'h8000, 16'h1234);
    add_ray(OP_START, 12'hABC, 24'h20000, 0, 16'h7FFF, 16'h0, 16'hFFFF); // abandon
    add_ray(OP_START, 12'h001, 24'h30000, 0, 16'h0, 16'h1, 16'h0001);
    add_advances(3);
    drain();
    set_regs(12'd2048, 12'd1024, 12'd256, 12'd256);
    add_random(150);
    drain();
    set_regs(12'd1, 12'hC00, 12'd1, 12'd1);              // smallest, offset -1024
    add_random(60);
    drain();
    set_regs(12'd0, 12'h7FF, 12'd0, 12'h1FF);            // out of range, clamped
    add_random(60);
    drain();
    set_regs(12'hFFF, 12'h800, 12'h1FF, 12'd0);
    add_random(60);
    drain();
    repeat (5) begin
      set_regs(12'($urandom_range(16, 2048)), 12'($urandom_range(0, 63) - 32),
               12'($urandom_range(1, 256)), 12'($urandom_range(1, 256)));
      add_random(150);
      drain();
    end
    set_regs(12'd480, 12'd0, 12'd64, 12'd64);
    no_idle = 1;
    add_random(150);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("textured_wall_column_stepper_tb: done, clean");
    else $display("textured_wall_column_stepper_tb: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/core/twcs_pkg.sv
rtl/core/twcs_fifo.sv
rtl/core/twcs_div.sv
rtl/core/twcs_back.sv
rtl/core/textured_wall_column_stepper.sv
bench/textured_wall_column_stepper_tb.sv
